/* hw/rtl/cbf_pkg.sv */
// Shared types and constants for the counting Bloom filter.
// Used by cbf_ctrl, cbf_dpath and counting_bloom_filter_unit.
package cbf_pkg;

	localparam int SLOTS_DEF       = 65536;
	localparam int HASHES_DEF      = 4;
	localparam int COUNTER_MAX_DEF = 255;

	localparam int CTR_W  = 8;
	localparam int STAT_W = 64;
	localparam int USED_W = 17;
	localparam int KEY_W  = 64;

	typedef enum logic [1:0] {
		CMD_QUERY  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key_hash;
	} req_t;

	typedef struct packed {
		logic              maybe_present;
		logic [STAT_W-1:0] query_count;
		logic [STAT_W-1:0] rejected_count;
		logic [STAT_W-1:0] saturated_count;
		logic [USED_W-1:0] used_slots;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic start;   // latch the accepted request
		logic issue;   // read the next slot of the request
		logic sweep;   // zero one slot of the clearing pass
		logic finish;  // fold the totals and load the response
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;
	} dp_sts_t;

endpackage

/* hw/rtl/cbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/cbf_ctrl.sv */
// Sequencer for the counting Bloom filter: handshakes and slot stepping.
// Depends on cbf_pkg.
module cbf_ctrl import cbf_pkg::*; #(
	parameter int HASHES = HASHES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  cmd_t    req_cmd,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dp_cmd_t dp_cmd,
	input  dp_sts_t dp_sts
);

	localparam int IW = (HASHES > 1) ? $clog2(HASHES) : 1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cnt_q;
	logic          rsp_valid_q;
	logic          accept;
	logic          out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		dp_cmd        = '0;
		dp_cmd.start  = accept;
		dp_cmd.issue  = (state_q == ST_ISSUE);
		dp_cmd.sweep  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		dp_cmd.finish = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (dp_sts.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (req_cmd == CMD_CLEAR) ? ST_CLEAR : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(HASHES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (dp_sts.sweep_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/cbf_dpath.sv */
// Datapath: slot index stepping, slot read-modify-write, totals, response register.
// Depends on cbf_pkg and cbf_ram.
module cbf_dpath import cbf_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int COUNTER_MAX = COUNTER_MAX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	output rsp_t    rsp,
	input  dp_cmd_t dp_cmd,
	output dp_sts_t dp_sts
);

	localparam int AW = $clog2(SLOTS);
	localparam logic [AW-1:0]    IDX_MASK = AW'(SLOTS - 1);
	localparam logic [AW-1:0]    LAST_IDX = AW'(SLOTS - 1);
	localparam logic [CTR_W-1:0] CMAX     = CTR_W'(COUNTER_MAX);

	cmd_t              cmd_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     stride_q;
	logic              present_q;
	logic              proc_s1;
	logic [AW-1:0]     addr_s1;
	logic              proc_s2;
	logic [AW-1:0]     addr_s2;
	logic [CTR_W-1:0]  data_s2;
	logic [AW-1:0]     sweep_addr_q;
	logic [STAT_W-1:0] queries_q;
	logic [STAT_W-1:0] rejects_q;
	logic [STAT_W-1:0] sats_q;
	logic [USED_W-1:0] used_q;
	rsp_t              rsp_q;

	logic [AW-1:0]     rd_addr;
	logic [CTR_W-1:0]  rd_data;
	logic [CTR_W-1:0]  cur;
	logic [CTR_W-1:0]  nxt;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CTR_W-1:0]  wdata;
	logic              is_query;
	logic              miss;

	assign rd_addr = pos_q & IDX_MASK;

	// The previous slot's write lands in the same cycle as this read: forward it.
	assign cur = (proc_s2 && (addr_s2 == addr_s1)) ? data_s2 : rd_data;

	always_comb begin
		nxt = cur;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (cur < CMAX) begin
					nxt = cur + CTR_W'(1);
				end
			end
			CMD_DELETE: begin
				if ((cur != '0) && (cur < CMAX)) begin
					nxt = cur - CTR_W'(1);
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign we    = dp_cmd.sweep || (proc_s1 && ((cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE)));
	assign waddr = dp_cmd.sweep ? sweep_addr_q : addr_s1;
	assign wdata = dp_cmd.sweep ? '0 : nxt;

	cbf_ram #(
		.WIDTH(CTR_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign dp_sts.sweep_last = (sweep_addr_q == LAST_IDX);

	assign is_query = (cmd_q == CMD_QUERY);
	assign miss     = is_query && !present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_s1      <= 1'b0;
			proc_s2      <= 1'b0;
			sweep_addr_q <= '0;
			queries_q    <= '0;
			rejects_q    <= '0;
			sats_q       <= '0;
			used_q       <= '0;
		end else begin
			proc_s1 <= dp_cmd.issue;
			proc_s2 <= proc_s1;
			if (dp_cmd.sweep) begin
				sweep_addr_q <= dp_sts.sweep_last ? '0 : sweep_addr_q + AW'(1);
			end
			if (dp_cmd.start && (req.cmd == CMD_CLEAR)) begin
				sweep_addr_q <= '0;
				queries_q    <= '0;
				rejects_q    <= '0;
				sats_q       <= '0;
				used_q       <= '0;
			end
			if (proc_s1) begin
				if (cmd_q == CMD_INSERT) begin
					if (cur >= CMAX) begin
						sats_q <= sats_q + STAT_W'(1);
					end else if (cur == '0) begin
						used_q <= used_q + USED_W'(1);
					end
				end
				if ((cmd_q == CMD_DELETE) && (cur == CTR_W'(1)) && (cur < CMAX)) begin
					used_q <= used_q - USED_W'(1);
				end
			end
			if (dp_cmd.finish) begin
				if (is_query) begin
					queries_q <= queries_q + STAT_W'(1);
				end
				if (miss) begin
					rejects_q <= rejects_q + STAT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			cmd_q     <= req.cmd;
			pos_q     <= req.key_hash[AW-1:0];
			stride_q  <= req.key_hash[32 +: AW] | AW'(1);
			present_q <= 1'b1;
		end
		if (dp_cmd.issue) begin
			pos_q <= pos_q + stride_q;
		end
		addr_s1 <= rd_addr;
		addr_s2 <= addr_s1;
		data_s2 <= nxt;
		if (proc_s1 && is_query && (cur == '0)) begin
			present_q <= 1'b0;
		end
		if (dp_cmd.finish) begin
			rsp_q.maybe_present   <= is_query && present_q;
			rsp_q.query_count     <= queries_q + STAT_W'(is_query);
			rsp_q.rejected_count  <= rejects_q + STAT_W'(miss);
			rsp_q.saturated_count <= sats_q;
			rsp_q.used_slots      <= used_q;
		end
	end

	assign rsp = rsp_q;

endmodule

/* hw/rtl/counting_bloom_filter_unit.sv */
// Top level of the counting Bloom filter: controller, datapath and slot memory.
// Depends on cbf_pkg, cbf_ctrl, cbf_dpath (which holds cbf_ram).
//
//   channel   | signals                    | payload
//   ----------+----------------------------+---------------------------------
//   request   | req_valid in, req_stall out| req_t: cmd, key_hash
//   response  | rsp_valid out, rsp_stall in| rsp_t: maybe_present and totals
//
// Query, insert and delete step through ISSUE, reading one slot per cycle through the
// single slot memory, then DRAIN to write the last slot, DONE to load the response
// register and back to idle to take the next request. Clear zeroes one slot per cycle.
// After reset the slot memory is swept before the first request is taken.
// A response waiting under rsp_stall does not block the next request; it only
// holds the block at the end of that request until the response is taken.
module counting_bloom_filter_unit import cbf_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int HASHES      = HASHES_DEF,
	parameter int COUNTER_MAX = COUNTER_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	cbf_ctrl #(
		.HASHES(HASHES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_cmd  (req.cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.dp_cmd   (dp_cmd),
		.dp_sts   (dp_sts)
	);

	cbf_dpath #(
		.SLOTS      (SLOTS),
		.COUNTER_MAX(COUNTER_MAX)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.dp_cmd(dp_cmd),
		.dp_sts(dp_sts)
	);

endmodule

/* test/counting_bloom_filter_unit_tb.sv */
// Self-checking testbench for counting_bloom_filter_unit: a tracker class mirrors the
// slot counters and totals, and plain tasks drive requests through the valid/stall channels.
// Depends on cbf_pkg and the counting_bloom_filter_unit RTL.
module counting_bloom_filter_unit_tb import cbf_pkg::*; ();

	class filter_tracker;
		bit [CTR_W-1:0]  slot_ctr [SLOTS_DEF];
		bit [STAT_W-1:0] queries, rejections, saturations;
		bit [USED_W-1:0] used;
		rsp_t            pending_totals [$];
		int              errors, hits, sat_touches, peak_used;
		int              cmd_seen [4];

		function void clear_all();
			slot_ctr = '{default: '0};
			queries = '0;
			rejections = '0;
			saturations = '0;
			used = '0;
		endfunction

		function int unsigned slot_index(bit [31:0] base, bit [31:0] stride, int unsigned i);
			bit [31:0] pos;
			pos = base + i * stride;
			return (pos & (SLOTS_DEF - 1)) % SLOTS_DEF;
		endfunction

		function rsp_t next_totals(req_t r);
			rsp_t        e;
			bit [31:0]   base, stride;
			int unsigned s;
			bit          hit;
			e = '0;
			hit = 1'b0;
			base = r.key_hash[31:0];
			stride = r.key_hash[63:32] | 32'd1;
			case (r.cmd)
				CMD_QUERY: begin
					hit = 1'b1;
					queries++;
					for (int unsigned i = 0; i < HASHES_DEF; i++) begin
						s = slot_index(base, stride, i);
						// stop at the first empty slot, counting one rejection
						if (slot_ctr[s] == 0) begin
							hit = 1'b0;
							rejections++;
							break;
						end
					end
				end
				CMD_INSERT: begin
					for (int unsigned i = 0; i < HASHES_DEF; i++) begin
						s = slot_index(base, stride, i);
						if (slot_ctr[s] >= COUNTER_MAX_DEF) begin
							saturations++;
							sat_touches++;
						end else begin
							if (slot_ctr[s] == 0)
								used++;
							slot_ctr[s]++;
						end
					end
				end
				CMD_DELETE: begin
					for (int unsigned i = 0; i < HASHES_DEF; i++) begin
						s = slot_index(base, stride, i);
						// empty and saturated slots hold their value
						if (slot_ctr[s] != 0 && slot_ctr[s] < COUNTER_MAX_DEF) begin
							if (slot_ctr[s] == 1)
								used--;
							slot_ctr[s]--;
						end
					end
				end
				default: clear_all();
			endcase
			if (hit)
				hits++;
			if (used > peak_used)
				peak_used = used;
			e.maybe_present = hit;
			e.query_count = queries;
			e.rejected_count = rejections;
			e.saturated_count = saturations;
			e.used_slots = used;
			return e;
		endfunction

		function void note_request(req_t r);
			cmd_seen[r.cmd]++;
			pending_totals.push_back(next_totals(r));
		endfunction

		task report_mismatch(string msg);
			if (errors < 40)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t e;
			if (pending_totals.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				e = pending_totals.pop_front();
				if (got.maybe_present !== e.maybe_present)
					report_mismatch($sformatf("maybe_present %b, want %b",
						got.maybe_present, e.maybe_present));
				if (got.query_count !== e.query_count)
					report_mismatch($sformatf("query_count %0d, want %0d",
						got.query_count, e.query_count));
				if (got.rejected_count !== e.rejected_count)
					report_mismatch($sformatf("rejected_count %0d, want %0d",
						got.rejected_count, e.rejected_count));
				if (got.saturated_count !== e.saturated_count)
					report_mismatch($sformatf("saturated_count %0d, want %0d",
						got.saturated_count, e.saturated_count));
				if (got.used_slots !== e.used_slots)
					report_mismatch($sformatf("used_slots %0d, want %0d",
						got.used_slots, e.used_slots));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	filter_tracker tracker = new();
	int snd_idle_pct = 20;
	int rcv_idle_pct = 82;
	bit hold_req = 1'b0;
	bit [63:0] key_pool [16];

	counting_bloom_filter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("counting_bloom_filter_unit_tb: done, errors");
		$finish;
	end

	// Response side: random stall, or a long hold-off on request from the stimulus.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	// Call at a rising edge; returns at the edge where the request is taken.
	task automatic send_req(req_t r);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		tracker.note_request(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_totals.size() != 0);
	endtask

	function automatic bit [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic run_directed();
		// empty table, then base 0 / stride 1 and the all-ones key at the top of the table
		send_req(req_t'{CMD_QUERY,  64'h0});
		send_req(req_t'{CMD_INSERT, 64'h0});
		send_req(req_t'{CMD_QUERY,  64'h0});
		send_req(req_t'{CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF});
		send_req(req_t'{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF});
		send_req(req_t'{CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF});
		send_req(req_t'{CMD_DELETE, 64'h0});
		// delete of empty slots changes nothing
		send_req(req_t'{CMD_DELETE, 64'h0});
		send_req(req_t'{CMD_QUERY,  64'h0});
		// even stride is forced odd; partial overlap with base 0
		send_req(req_t'{CMD_INSERT, 64'h0000_0002_0000_0000});
		send_req(req_t'{CMD_QUERY,  64'h0});
		send_req(req_t'{CMD_QUERY,  64'h0000_0002_0000_0000});
		// base bits above the table size are masked off
		send_req(req_t'{CMD_QUERY,  64'h0000_0002_ABCD_0000});
		send_req(req_t'{CMD_INSERT, 64'h8000_0000_8000_0000});
		send_req(req_t'{CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF});
		send_req(req_t'{CMD_CLEAR,  64'h5A5A_5A5A_A5A5_A5A5});
		// totals read zero after clear
		send_req(req_t'{CMD_QUERY,  64'h8000_0000_8000_0000});
		send_req(req_t'{CMD_INSERT, 64'h7FFF_FFFF_7FFF_FFFF});
		send_req(req_t'{CMD_QUERY,  64'h7FFF_FFFF_7FFF_FFFF});
	endtask

	task automatic run_mixed(int n, int clears_max, bit with_hold);
		int   clears_left;
		int   pick;
		req_t r;
		clears_left = clears_max;
		foreach (key_pool[j])
			key_pool[j] = rand_key();
		for (int k = 0; k < n; k++) begin
			// hold the response side off while requests keep coming
			if (with_hold && k == n / 4)
				hold_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 3 && clears_left > 0) begin
				r.cmd = CMD_CLEAR;
				clears_left--;
			end else if (pick < 38) begin
				r.cmd = CMD_QUERY;
			end else if (pick < 72) begin
				r.cmd = CMD_INSERT;
			end else begin
				r.cmd = CMD_DELETE;
			end
			if ($urandom_range(99) < 85)
				r.key_hash = key_pool[$urandom_range(15)];
			else
				r.key_hash = rand_key();
			if ($urandom_range(99) < 3)
				key_pool[$urandom_range(15)] = rand_key();
			send_req(r);
		end
	endtask

	// Hammer one slot through keys sharing the low base bits until it saturates.
	task automatic run_saturation(int n);
		bit [15:0] hot;
		bit [63:0] hot_keys [4];
		int        pick;
		req_t      r;
		hot = 16'($urandom_range(65535));
		foreach (hot_keys[j]) begin
			hot_keys[j] = rand_key();
			hot_keys[j][15:0] = hot;
		end
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				wait_drained();
			if ($urandom_range(99) < 25) begin
				r.key_hash = rand_key();
				r.key_hash[15:0] = hot;
			end else begin
				r.key_hash = hot_keys[$urandom_range(3)];
			end
			pick = $urandom_range(99);
			if (pick < 72) begin
				r.cmd = CMD_INSERT;
			end else if (pick < 80) begin
				r.cmd = CMD_DELETE;
			end else if (pick < 96) begin
				r.cmd = CMD_QUERY;
			end else begin
				r.cmd = cmd_t'($urandom_range(2));
				r.key_hash = rand_key();
			end
			send_req(r);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_mixed(550, 2, 1'b1);

		snd_idle_pct = 82;
		rcv_idle_pct = 20;
		run_saturation(550);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_mixed(550, 2, 1'b0);

		wait_drained();
		repeat (HASHES_DEF + 12) @(posedge clk);
		if (tracker.pending_totals.size() != 0)
			tracker.report_mismatch($sformatf("%0d responses never arrived",
				tracker.pending_totals.size()));

		$display("covered %0d query, %0d insert, %0d delete, %0d clear requests",
			tracker.cmd_seen[CMD_QUERY], tracker.cmd_seen[CMD_INSERT],
			tracker.cmd_seen[CMD_DELETE], tracker.cmd_seen[CMD_CLEAR]);
		$display("%0d present answers, %0d saturated slot touches, peak used slots %0d",
			tracker.hits, tracker.sat_touches, tracker.peak_used);
		if (tracker.errors == 0)
			$display("counting_bloom_filter_unit_tb: done, clean");
		else
			$display("counting_bloom_filter_unit_tb: done, errors");
		$finish;
	end

endmodule
